// File: src/rmie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmie_pkg
// Opcodes, status codes and the decoded instruction record shared by the
// front end, the queue and the execute unit.
// ----------------------------------------------------------------------------
package rmie_pkg;

	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_MUL    = 5'd1,
		OP_SUB    = 5'd2,
		OP_DIV    = 5'd3,
		OP_COPY   = 5'd4,
		OP_LDI    = 5'd5,
		OP_LOAD   = 5'd6,
		OP_STORE  = 5'd7,
		OP_EQ     = 5'd8,
		OP_LT     = 5'd9,
		OP_LE     = 5'd10,
		OP_GT     = 5'd11,
		OP_GE     = 5'd12,
		OP_JMP    = 5'd13,
		OP_JMPZ   = 5'd14,
		OP_JMPREG = 5'd15,
		OP_PRINT  = 5'd16
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ILLEGAL = 2'd1,
		ST_RANGE   = 2'd2,
		ST_DIVZERO = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_READ,
		EX_MUL,
		EX_DIV,
		EX_MEM,
		EX_DONE
	} ex_state_t;

	// decoded instruction passed from front end to execute
	typedef struct packed {
		logic [4:0]  op;
		logic        illegal;
		logic [9:0]  cur_addr;
		logic [9:0]  field_a;
		logic [31:0] field_b;
		logic [31:0] field_c;
	} instr_t;

endpackage

// File: src/rmie_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmie_front
// Takes the instruction beat, classifies the opcode and queues it for the
// execute unit in a two-entry queue.
// ----------------------------------------------------------------------------
module rmie_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [4:0]      req_type,
	input  logic [9:0]      cur_addr,
	input  logic [9:0]      field_a,
	input  logic [31:0]     field_b,
	input  logic [31:0]     field_c,
	input  logic            pop,
	output logic            q_valid,
	output rmie_pkg::instr_t q_head,
	output logic            q_full
);
	import rmie_pkg::*;

	instr_t      entry_q [2];
	logic        rd_ptr_q;
	logic        wr_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	instr_t      in_item;

	assign q_full  = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_head  = entry_q[rd_ptr_q];
	assign push    = start && !q_full;

	always_comb begin
		in_item.op       = req_type;
		in_item.illegal  = (req_type > OP_PRINT);
		in_item.cur_addr = cur_addr;
		in_item.field_a  = field_a;
		in_item.field_b  = field_b;
		in_item.field_c  = field_c;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/rmie_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmie_exec
// Execute unit: register file, data memory, multiplier, radix-2 divider
// and result register.
// ----------------------------------------------------------------------------
module rmie_exec #(
	parameter int NUM_REGS   = 32,
	parameter int MEM_DEPTH  = 1024,
	parameter int PROG_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      mem_base,
	input  logic             q_valid,
	input  rmie_pkg::instr_t q_head,
	output logic             pop,
	output logic             done,
	output logic [9:0]       next_addr,
	output logic [1:0]       status,
	output logic             print_valid,
	output logic [4:0]       print_reg,
	output logic [31:0]      print_value
);
	import rmie_pkg::*;

	localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int MW = $clog2(MEM_DEPTH);

	ex_state_t   state_q, state_d;
	logic [31:0] regs_q [NUM_REGS];
	logic [31:0] mem [MEM_DEPTH];
	logic [31:0] mem_rd_q;

	instr_t      ins_q;
	logic [31:0] ra_q, rb_q, rc_q;
	logic [31:0] mul_q;
	logic [5:0]  div_cnt_q;
	logic [31:0] quo_q, rem_q, dvs_q;
	logic        neg_q;

	logic [RW-1:0] ia;
	logic [33:0]   addr_calc;
	logic          addr_ok;
	logic [MW-1:0] maddr;
	logic [32:0]   rem_sh;
	logic [32:0]   rem_sub;

	// operand register indexes, raw bits modulo the register count
	function automatic logic [RW-1:0] ridx(input logic [31:0] v);
		logic [31:0] m;
		m = v % NUM_REGS;
		return m[RW-1:0];
	endfunction

	function automatic logic [9:0] pwrap(input logic [31:0] v);
		logic [31:0] m;
		m = v % PROG_DEPTH;
		return m[9:0];
	endfunction

	assign ia = ridx({22'd0, ins_q.field_a});

	always_comb begin
		if (ins_q.op == OP_STORE) begin
			addr_calc = {{2{ra_q[31]}}, ra_q} + {{2{ins_q.field_b[31]}}, ins_q.field_b}
				- {18'd0, mem_base};
		end else begin
			addr_calc = {{2{rb_q[31]}}, rb_q} + {{2{ins_q.field_c[31]}}, ins_q.field_c}
				- {18'd0, mem_base};
		end
		addr_ok = !addr_calc[33] && (addr_calc < 34'(MEM_DEPTH));
		maddr   = addr_calc[MW-1:0];
	end

	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			EX_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = EX_READ;
				end
			end
			EX_READ: begin
				priority if (ins_q.op == OP_MUL) begin
					state_d = EX_MUL;
				end else if (ins_q.op == OP_DIV && rc_q != 32'd0) begin
					state_d = EX_DIV;
				end else if ((ins_q.op == OP_LOAD || ins_q.op == OP_STORE) && addr_ok) begin
					state_d = EX_MEM;
				end else begin
					state_d = EX_DONE;
				end
			end
			EX_MUL:  state_d = EX_DONE;
			EX_DIV:  state_d = (div_cnt_q == 6'd32) ? EX_DONE : EX_DIV;
			EX_MEM:  state_d = EX_DONE;
			EX_DONE: state_d = EX_IDLE;
			default: state_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// data memory
	always_ff @(posedge clk) begin
		if (state_q == EX_READ && ins_q.op == OP_STORE && addr_ok) begin
			mem[maddr] <= rc_q;
		end
		mem_rd_q <= mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ins_q <= q_head;
		end
		if (state_q == EX_IDLE) begin
			div_cnt_q <= 6'd0;
		end
		if (state_q == EX_READ) begin
			mul_q     <= rb_q * rc_q;
			neg_q     <= rb_q[31] ^ rc_q[31];
			quo_q     <= rb_q[31] ? (32'd0 - rb_q) : rb_q;
			dvs_q     <= rc_q[31] ? (32'd0 - rc_q) : rc_q;
			rem_q     <= 32'd0;
		end
		if (state_q == EX_DIV && div_cnt_q != 6'd32) begin
			div_cnt_q <= div_cnt_q + 6'd1;
			if (!rem_sub[32]) begin
				rem_q <= rem_sub[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	logic [31:0] wb_data;
	logic        wb_en;
	logic [31:0] res_next;
	logic [1:0]  res_status;

	always_comb begin
		wb_en      = 1'b0;
		wb_data    = 32'd0;
		res_next   = {22'd0, pwrap({22'd0, ins_q.cur_addr} + 32'd1)};
		res_status = ST_OK;
		if (state_q == EX_DONE) begin
			if (ins_q.illegal) begin
				res_status = ST_ILLEGAL;
				res_next   = {22'd0, ins_q.cur_addr};
			end else begin
				unique case (op_t'(ins_q.op))
					OP_ADD:  begin wb_en = 1'b1; wb_data = rb_q + rc_q; end
					OP_MUL:  begin wb_en = 1'b1; wb_data = mul_q; end
					OP_SUB:  begin wb_en = 1'b1; wb_data = rb_q - rc_q; end
					OP_DIV: begin
						if (rc_q == 32'd0) begin
							res_status = ST_DIVZERO;
						end else begin
							wb_en   = 1'b1;
							wb_data = neg_q ? (32'd0 - quo_q) : quo_q;
						end
					end
					OP_COPY: begin wb_en = 1'b1; wb_data = rb_q; end
					OP_LDI:  begin wb_en = 1'b1; wb_data = ins_q.field_b; end
					OP_LOAD: begin
						if (addr_ok) begin
							wb_en   = 1'b1;
							wb_data = mem_rd_q;
						end else begin
							res_status = ST_RANGE;
						end
					end
					OP_STORE: begin
						if (!addr_ok) begin
							res_status = ST_RANGE;
						end
					end
					OP_EQ: begin wb_en = 1'b1; wb_data = {31'd0, rb_q == rc_q}; end
					OP_LT: begin
						wb_en = 1'b1; wb_data = {31'd0, $signed(rb_q) < $signed(rc_q)};
					end
					OP_LE: begin
						wb_en = 1'b1; wb_data = {31'd0, $signed(rb_q) <= $signed(rc_q)};
					end
					OP_GT: begin
						wb_en = 1'b1; wb_data = {31'd0, $signed(rb_q) > $signed(rc_q)};
					end
					OP_GE: begin
						wb_en = 1'b1; wb_data = {31'd0, $signed(rb_q) >= $signed(rc_q)};
					end
					OP_JMP:    res_next = {22'd0, pwrap({22'd0, ins_q.field_a})};
					OP_JMPZ: begin
						if (rb_q == 32'd0) begin
							res_next = {22'd0, pwrap({22'd0, ins_q.field_a})};
						end
					end
					OP_JMPREG: res_next = {22'd0, pwrap(ra_q)};
					OP_PRINT:  ;
					default:   ;
				endcase
			end
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= 32'd0;
			end
		end else if (wb_en) begin
			regs_q[ia] <= wb_data;
		end
	end

	// operand read as the beat leaves the queue
	always_ff @(posedge clk) begin
		if (state_q == EX_IDLE && q_valid) begin
			ra_q <= regs_q[ridx({22'd0, q_head.field_a})];
			rb_q <= regs_q[ridx(q_head.field_b)];
			rc_q <= regs_q[ridx(q_head.field_c)];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == EX_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EX_DONE) begin
			next_addr   <= res_next[9:0];
			status      <= res_status;
			print_valid <= !ins_q.illegal && ins_q.op == OP_PRINT;
			print_reg   <= (!ins_q.illegal && ins_q.op == OP_PRINT) ? 5'(ia) : 5'd0;
			print_value <= (!ins_q.illegal && ins_q.op == OP_PRINT) ? ra_q : 32'd0;
		end
	end

endmodule

// File: src/register_machine_instruction_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_instruction_execute
// Runs one load-store register machine instruction per beat.
// steps: the beat is queued, popped into the read state, passes the multiply,
// divide or memory state where needed, then the done state that registers done;
// new beats are accepted while one executes; two beats may queue in front
// busy rises while the two-entry queue is full; the execute sequencer and the
// 32-step divider set the rate. reset clears registers, queue and mem_base
// done pulses one cycle and cannot be stalled
// ----------------------------------------------------------------------------
module register_machine_instruction_execute #(
	parameter int NUM_REGS   = 32,
	parameter int MEM_DEPTH  = 1024,
	parameter int PROG_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  req_type,
	input  logic [9:0]  cur_addr,
	input  logic [9:0]  field_a,
	input  logic [31:0] field_b,
	input  logic [31:0] field_c,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output logic [9:0]  next_addr,
	output logic [1:0]  status,
	output logic        print_valid,
	output logic [4:0]  print_reg,
	output logic [31:0] print_value
);
	import rmie_pkg::*;

	logic        q_valid;
	logic        q_full;
	logic        pop;
	instr_t      q_head;
	logic [15:0] mem_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= 16'd0;
		end else if (cfg_we) begin
			mem_base_q <= cfg_wdata;
		end
	end

	assign busy = q_full;

	rmie_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.cur_addr (cur_addr),
		.field_a  (field_a),
		.field_b  (field_b),
		.field_c  (field_c),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_full   (q_full)
	);

	rmie_exec #(
		.NUM_REGS   (NUM_REGS),
		.MEM_DEPTH  (MEM_DEPTH),
		.PROG_DEPTH (PROG_DEPTH)
	) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.mem_base    (mem_base_q),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.done        (done),
		.next_addr   (next_addr),
		.status      (status),
		.print_valid (print_valid),
		.print_reg   (print_reg),
		.print_value (print_value)
	);

endmodule

// File: src/rmie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmie_checker
// Port-level checks on the result strobe and its payload.
// ----------------------------------------------------------------------------
module rmie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic [1:0]  status,
	input logic        print_valid,
	input logic [4:0]  print_reg,
	input logic [31:0] print_value
);
	import rmie_pkg::*;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && print_valid |-> status == ST_OK) else $error("print with error");

	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !print_valid |-> print_reg == 5'd0 && print_value == 32'd0)
		else $error("print fields not clear");

endmodule

bind register_machine_instruction_execute rmie_checker u_rmie_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.done        (done),
	.status      (status),
	.print_valid (print_valid),
	.print_reg   (print_reg),
	.print_value (print_value)
);
